[hw/rtl/qtc_pkg.sv]
// ----------------------------------------------------------------------------
// qtc_pkg: shared widths, constants and types
// Sizing constants for the card rectangle pipeline and the records that pass
// between its units.
// ----------------------------------------------------------------------------
package qtc_pkg;

	// Geometry and fixed point
	localparam int COORD_BITS = 12;
	localparam int IN_W       = 12;
	localparam int FRAC_BITS  = 8;
	localparam int SIDE_W     = COORD_BITS + 9;
	localparam int RAD_W      = 2 * SIDE_W;
	localparam int SQ_IN_W    = 2 * COORD_BITS;

	// Ratio compare datapath
	localparam int SUM_W  = SIDE_W + 1;
	localparam int SQ_W   = 2 * SIDE_W;
	localparam int P_W    = SUM_W + SQ_W;
	localparam int CH_W   = SUM_W;
	localparam int N_CH   = 3;
	localparam int N_DCH  = 2;
	localparam int PX_W   = N_CH * CH_W;
	localparam int PP_W   = CH_W + SIDE_W;
	localparam int ROW_W  = PX_W + SIDE_W;
	localparam int TOT_W  = PX_W + SQ_W;

	// Sizing
	localparam int W_W     = 13;
	localparam int H_W     = 14;
	localparam int LEM_W   = 12;
	localparam int WD_W    = SIDE_W - FRAC_BITS;
	localparam int WZ_W    = (WD_W > W_W) ? WD_W : W_W;
	localparam int N_W     = 23;
	localparam int Q_W     = 15;
	localparam int REC_W   = 15;
	localparam int PR_W    = N_W + REC_W;
	localparam int DIV_K   = 24;
	localparam int CARD_SHORT = 540;
	localparam int CARD_LONG  = 856;
	localparam int REC_SHORT  = (1 << DIV_K) / CARD_SHORT;
	localparam int REC_LONG   = (1 << DIV_K) / CARD_LONG;
	localparam int W_MAX   = 8191;
	localparam int H_MAX   = 16383;

	// Side lanes
	localparam int N_LANES  = 4;
	localparam int LN_TOP   = 0;
	localparam int LN_BOT   = 1;
	localparam int LN_LEFT  = 2;
	localparam int LN_RIGHT = 3;

	// Output queue
	localparam int FIFO_DEPTH = 2;
	localparam int CNT_W      = 2;

	typedef struct packed {
		logic              degen;
		logic [SIDE_W-1:0] tb_min;
	} side_info_t;

	typedef struct packed {
		logic              land;
		logic              degen;
		logic [SIDE_W-1:0] tb_min;
	} cmp_res_t;

	typedef struct packed {
		logic [W_W-1:0] width_px;
		logic [H_W-1:0] height_px;
		logic           landscape;
		logic           degenerate;
	} rect_t;

	// Keep the low COORD_BITS of a coordinate, zero-extending if narrower.
	function automatic logic [COORD_BITS-1:0] mask_coord(input logic [IN_W-1:0] v);
		logic [IN_W+COORD_BITS-1:0] t;
		t = {{COORD_BITS{1'b0}}, v};
		return t[COORD_BITS-1:0];
	endfunction

	function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

[hw/rtl/qtc_ifs.sv]
// ----------------------------------------------------------------------------
// qtc_ifs: channel interfaces
// Quad corner input, rectangle result output and register write channels.
// ----------------------------------------------------------------------------
interface qtc_quad_if;
	logic                  valid;
	logic                  ready;
	logic [qtc_pkg::IN_W-1:0] top_left_x;
	logic [qtc_pkg::IN_W-1:0] top_left_y;
	logic [qtc_pkg::IN_W-1:0] top_right_x;
	logic [qtc_pkg::IN_W-1:0] top_right_y;
	logic [qtc_pkg::IN_W-1:0] bottom_left_x;
	logic [qtc_pkg::IN_W-1:0] bottom_left_y;
	logic [qtc_pkg::IN_W-1:0] bottom_right_x;
	logic [qtc_pkg::IN_W-1:0] bottom_right_y;

	modport source (output valid, top_left_x, top_left_y, top_right_x, top_right_y,
		bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y, input ready);
	modport sink (input valid, top_left_x, top_left_y, top_right_x, top_right_y,
		bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y, output ready);
endinterface

interface qtc_rect_if;
	logic                     valid;
	logic                     ready;
	logic [qtc_pkg::W_W-1:0]  width_px;
	logic [qtc_pkg::H_W-1:0]  height_px;
	logic                     landscape;
	logic                     degenerate;

	modport source (output valid, width_px, height_px, landscape, degenerate,
		input ready);
	modport sink (input valid, width_px, height_px, landscape, degenerate,
		output ready);
endinterface

interface qtc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [qtc_pkg::LEM_W-1:0] long_edge_min;

	modport source (output valid, long_edge_min, input ready);
	modport sink (input valid, long_edge_min, output ready);
endinterface

[hw/rtl/qtc_isqrt4.sv]
// ----------------------------------------------------------------------------
// qtc_isqrt4: four-lane pipelined integer square root
// One result bit per stage, all four side lanes in lockstep.
// ----------------------------------------------------------------------------
module qtc_isqrt4 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [qtc_pkg::RAD_W-1:0]  rad [qtc_pkg::N_LANES],
	output logic                       out_valid,
	output logic [qtc_pkg::SIDE_W-1:0] root [qtc_pkg::N_LANES]
);

	localparam int SW = qtc_pkg::SIDE_W;
	localparam int RW = qtc_pkg::RAD_W;
	localparam int NL = qtc_pkg::N_LANES;

	logic          vld_s  [SW+1];
	logic [RW-1:0] rem_s  [SW+1][NL];
	logic [SW-1:0] root_s [SW+1][NL];

	assign vld_s[0] = in_valid;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			rem_s[0][l]  = rad[l];
			root_s[0][l] = '0;
		end
	end

	for (genvar k = 0; k < SW; k++) begin : g_stage
		localparam int B = SW - 1 - k;
		logic [RW-1:0] trial [NL];
		logic          take  [NL];

		// (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
		always_comb begin
			for (int l = 0; l < NL; l++) begin
				trial[l] = (RW'(root_s[k][l]) << (B + 1)) + (RW'(1) << (2 * B));
				take[l]  = (rem_s[k][l] >= trial[l]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < NL; l++) begin
					rem_s[k+1][l]  <= take[l] ? (rem_s[k][l] - trial[l]) : rem_s[k][l];
					root_s[k+1][l] <= take[l] ? (root_s[k][l] | (SW'(1) << B)) : root_s[k][l];
				end
			end
		end
	end

	assign out_valid = vld_s[SW];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			root[l] = root_s[SW][l];
		end
	end

endmodule

[hw/rtl/qtc_ratio_cmp.sv]
// ----------------------------------------------------------------------------
// qtc_ratio_cmp: perspective-corrected orientation compare
// Exact test (T+B)*Ylr^2*Dtb > (L+R)*Ytb^2*Dlr over eight stages.
// ----------------------------------------------------------------------------
module qtc_ratio_cmp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [qtc_pkg::SIDE_W-1:0] side [qtc_pkg::N_LANES],
	output logic                       out_valid,
	output qtc_pkg::cmp_res_t          res
);

	localparam int SW = qtc_pkg::SIDE_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	qtc_pkg::side_info_t info_s1, info_s2, info_s3, info_s4, info_s5, info_s6, info_s7;

	// stage 1
	logic [SW-1:0]                 y_lr_s1, mn_lr_s1, y_tb_s1, mn_tb_s1;
	logic [qtc_pkg::SUM_W-1:0]     yx_lr_s1, yx_tb_s1, sum_lr_s1, sum_tb_s1;
	// stage 2
	logic [qtc_pkg::SQ_W-1:0]      ysq_lr_s2, den_lr_s2, ysq_tb_s2, den_tb_s2;
	logic [qtc_pkg::SUM_W-1:0]     sum_lr_s2, sum_tb_s2;
	// stage 3
	logic [qtc_pkg::PP_W-1:0]      pa_lo_s3, pa_hi_s3, pb_lo_s3, pb_hi_s3;
	logic [qtc_pkg::SQ_W-1:0]      den_a_s3, den_b_s3;
	// stage 4
	logic [qtc_pkg::P_W-1:0]       pa_s4, pb_s4;
	logic [qtc_pkg::SQ_W-1:0]      den_a_s4, den_b_s4;
	// stage 5
	logic [qtc_pkg::PP_W-1:0]      ppa_s5 [qtc_pkg::N_CH][qtc_pkg::N_DCH];
	logic [qtc_pkg::PP_W-1:0]      ppb_s5 [qtc_pkg::N_CH][qtc_pkg::N_DCH];
	// stage 6
	logic [qtc_pkg::ROW_W-1:0]     rowa_s6 [qtc_pkg::N_DCH];
	logic [qtc_pkg::ROW_W-1:0]     rowb_s6 [qtc_pkg::N_DCH];
	// stage 7
	logic [qtc_pkg::TOT_W-1:0]     tota_s7, totb_s7;
	// stage 8
	qtc_pkg::cmp_res_t             res_s8;

	logic [SW-1:0]             t_c, b_c, l_c, r_c, mn_tb_c, mn_lr_c, mx_tb_c, mx_lr_c;
	logic [qtc_pkg::PX_W-1:0]  pxa_c, pxb_c;
	logic [qtc_pkg::ROW_W-1:0] rowa_c [qtc_pkg::N_DCH];
	logic [qtc_pkg::ROW_W-1:0] rowb_c [qtc_pkg::N_DCH];

	always_comb begin
		t_c = side[qtc_pkg::LN_TOP];
		b_c = side[qtc_pkg::LN_BOT];
		l_c = side[qtc_pkg::LN_LEFT];
		r_c = side[qtc_pkg::LN_RIGHT];
		mn_tb_c = (t_c < b_c) ? t_c : b_c;
		mx_tb_c = (t_c < b_c) ? b_c : t_c;
		mn_lr_c = (l_c < r_c) ? l_c : r_c;
		mx_lr_c = (l_c < r_c) ? r_c : l_c;
		pxa_c = qtc_pkg::PX_W'(pa_s4);
		pxb_c = qtc_pkg::PX_W'(pb_s4);
		for (int j = 0; j < qtc_pkg::N_DCH; j++) begin
			rowa_c[j] = '0;
			rowb_c[j] = '0;
			for (int i = 0; i < qtc_pkg::N_CH; i++) begin
				rowa_c[j] = rowa_c[j] + (qtc_pkg::ROW_W'(ppa_s5[i][j]) << (i * qtc_pkg::CH_W));
				rowb_c[j] = rowb_c[j] + (qtc_pkg::ROW_W'(ppb_s5[i][j]) << (i * qtc_pkg::CH_W));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// pair terms: den = y^2 - (y-min)^2 = min * (2y - min)
			info_s1.degen  <= (mn_tb_c == '0) || (mn_lr_c == '0);
			info_s1.tb_min <= mn_tb_c;
			y_lr_s1   <= mx_lr_c;
			mn_lr_s1  <= mn_lr_c;
			yx_lr_s1  <= {mx_lr_c, 1'b0} - qtc_pkg::SUM_W'(mn_lr_c);
			y_tb_s1   <= mx_tb_c;
			mn_tb_s1  <= mn_tb_c;
			yx_tb_s1  <= {mx_tb_c, 1'b0} - qtc_pkg::SUM_W'(mn_tb_c);
			sum_lr_s1 <= qtc_pkg::SUM_W'(l_c) + qtc_pkg::SUM_W'(r_c);
			sum_tb_s1 <= qtc_pkg::SUM_W'(t_c) + qtc_pkg::SUM_W'(b_c);

			info_s2   <= info_s1;
			ysq_lr_s2 <= y_lr_s1 * y_lr_s1;
			ysq_tb_s2 <= y_tb_s1 * y_tb_s1;
			den_lr_s2 <= qtc_pkg::SQ_W'(mn_lr_s1 * yx_lr_s1);
			den_tb_s2 <= qtc_pkg::SQ_W'(mn_tb_s1 * yx_tb_s1);
			sum_lr_s2 <= sum_lr_s1;
			sum_tb_s2 <= sum_tb_s1;

			info_s3  <= info_s2;
			pa_lo_s3 <= sum_tb_s2 * ysq_lr_s2[SW-1:0];
			pa_hi_s3 <= sum_tb_s2 * ysq_lr_s2[2*SW-1:SW];
			pb_lo_s3 <= sum_lr_s2 * ysq_tb_s2[SW-1:0];
			pb_hi_s3 <= sum_lr_s2 * ysq_tb_s2[2*SW-1:SW];
			den_a_s3 <= den_tb_s2;
			den_b_s3 <= den_lr_s2;

			info_s4  <= info_s3;
			pa_s4    <= qtc_pkg::P_W'(pa_lo_s3) + (qtc_pkg::P_W'(pa_hi_s3) << SW);
			pb_s4    <= qtc_pkg::P_W'(pb_lo_s3) + (qtc_pkg::P_W'(pb_hi_s3) << SW);
			den_a_s4 <= den_a_s3;
			den_b_s4 <= den_b_s3;

			info_s5 <= info_s4;
			for (int i = 0; i < qtc_pkg::N_CH; i++) begin
				for (int j = 0; j < qtc_pkg::N_DCH; j++) begin
					ppa_s5[i][j] <= pxa_c[i*qtc_pkg::CH_W +: qtc_pkg::CH_W] * den_a_s4[j*SW +: SW];
					ppb_s5[i][j] <= pxb_c[i*qtc_pkg::CH_W +: qtc_pkg::CH_W] * den_b_s4[j*SW +: SW];
				end
			end

			info_s6 <= info_s5;
			rowa_s6 <= rowa_c;
			rowb_s6 <= rowb_c;

			info_s7 <= info_s6;
			tota_s7 <= qtc_pkg::TOT_W'(rowa_s6[0]) + (qtc_pkg::TOT_W'(rowa_s6[1]) << SW);
			totb_s7 <= qtc_pkg::TOT_W'(rowb_s6[0]) + (qtc_pkg::TOT_W'(rowb_s6[1]) << SW);

			// a zero side forces portrait
			res_s8.land   <= (tota_s7 > totb_s7) && !info_s7.degen;
			res_s8.degen  <= info_s7.degen;
			res_s8.tb_min <= info_s7.tb_min;
		end
	end

	assign out_valid = v_s8;
	assign res       = res_s8;

endmodule

[hw/rtl/qtc_sizer.sv]
// ----------------------------------------------------------------------------
// qtc_sizer: rectangle width and height
// Clamp width to the minimum and to W_MAX, then scale by the card aspect with a
// reciprocal multiply and one correction step, clamping height to H_MAX.
// ----------------------------------------------------------------------------
module qtc_sizer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  qtc_pkg::cmp_res_t         res,
	input  logic [qtc_pkg::LEM_W-1:0] lem,
	output logic                      out_valid,
	output qtc_pkg::rect_t            rect
);

	logic [qtc_pkg::N_W-1:0]   lem_prod_q;
	logic [qtc_pkg::Q_W-1:0]   lem_est_q;
	logic [qtc_pkg::LEM_W-1:0] lem_short_q;
	logic [qtc_pkg::N_W-1:0]   lem_rem_c;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [qtc_pkg::W_W-1:0] w_s1, w_s2, w_s3;
	logic land_s1, land_s2, land_s3, degen_s1, degen_s2, degen_s3;
	logic [qtc_pkg::N_W-1:0] n_s2, n_s3;
	logic [qtc_pkg::Q_W-1:0] q_s3;
	qtc_pkg::rect_t          rect_s4;

	logic [qtc_pkg::WZ_W-1:0] wd_c, wm_c, wz_c;
	logic [qtc_pkg::N_W-1:0]  div_c, rem_c;
	logic [qtc_pkg::Q_W-1:0]  qf_c;

	// minimum portrait width follows the register through lem_prod_q, lem_est_q and lem_short_q
	always_comb begin
		lem_rem_c = lem_prod_q - qtc_pkg::N_W'(lem_est_q * qtc_pkg::CARD_LONG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lem_prod_q  <= '0;
			lem_est_q   <= '0;
			lem_short_q <= '0;
		end else begin
			lem_prod_q  <= qtc_pkg::N_W'(lem * qtc_pkg::CARD_SHORT);
			lem_est_q   <= qtc_pkg::Q_W'((qtc_pkg::PR_W'(lem_prod_q) *
				qtc_pkg::PR_W'(qtc_pkg::REC_LONG)) >> qtc_pkg::DIV_K);
			lem_short_q <= (lem_rem_c >= qtc_pkg::N_W'(qtc_pkg::CARD_LONG)) ?
				qtc_pkg::LEM_W'(lem_est_q + 1'b1) : qtc_pkg::LEM_W'(lem_est_q);
		end
	end

	always_comb begin
		wd_c = qtc_pkg::WZ_W'(res.tb_min >> qtc_pkg::FRAC_BITS);
		wm_c = res.land ? qtc_pkg::WZ_W'(lem) : qtc_pkg::WZ_W'(lem_short_q);
		wz_c = (wd_c < wm_c) ? wm_c : wd_c;
		div_c = land_s3 ? qtc_pkg::N_W'(qtc_pkg::CARD_LONG) : qtc_pkg::N_W'(qtc_pkg::CARD_SHORT);
		rem_c = n_s3 - qtc_pkg::N_W'(q_s3 * div_c);
		qf_c  = (rem_c >= div_c) ? (q_s3 + 1'b1) : q_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1     <= (wz_c > qtc_pkg::WZ_W'(qtc_pkg::W_MAX)) ?
				qtc_pkg::W_W'(qtc_pkg::W_MAX) : qtc_pkg::W_W'(wz_c);
			land_s1  <= res.land;
			degen_s1 <= res.degen;

			n_s2     <= land_s1 ? qtc_pkg::N_W'(w_s1 * qtc_pkg::CARD_SHORT) :
				qtc_pkg::N_W'(w_s1 * qtc_pkg::CARD_LONG);
			w_s2     <= w_s1;
			land_s2  <= land_s1;
			degen_s2 <= degen_s1;

			q_s3     <= qtc_pkg::Q_W'((qtc_pkg::PR_W'(n_s2) * (land_s2 ?
				qtc_pkg::PR_W'(qtc_pkg::REC_LONG) : qtc_pkg::PR_W'(qtc_pkg::REC_SHORT)))
				>> qtc_pkg::DIV_K);
			n_s3     <= n_s2;
			w_s3     <= w_s2;
			land_s3  <= land_s2;
			degen_s3 <= degen_s2;

			rect_s4.width_px   <= w_s3;
			rect_s4.height_px  <= (qf_c > qtc_pkg::Q_W'(qtc_pkg::H_MAX)) ?
				qtc_pkg::H_W'(qtc_pkg::H_MAX) : qtc_pkg::H_W'(qf_c);
			rect_s4.landscape  <= land_s3;
			rect_s4.degenerate <= degen_s3;
		end
	end

	assign out_valid = v_s4;
	assign rect      = rect_s4;

endmodule

[hw/rtl/qtc_out_fifo.sv]
// ----------------------------------------------------------------------------
// qtc_out_fifo: two-entry result queue
// Decouples the pipeline from the result channel; drives the pipe enable.
// ----------------------------------------------------------------------------
module qtc_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qtc_pkg::rect_t in_rect,
	output logic           en,
	qtc_rect_if.source     rect
);

	qtc_pkg::rect_t              mem_q [qtc_pkg::FIFO_DEPTH];
	logic [qtc_pkg::CNT_W-1:0]   cnt_q;
	logic                        wr_q, rd_q;
	logic                        push, pop;
	qtc_pkg::rect_t              head;

	assign en   = (cnt_q != qtc_pkg::CNT_W'(qtc_pkg::FIFO_DEPTH)) || rect.ready;
	assign push = en && in_valid;
	assign pop  = rect.valid && rect.ready;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_rect;
		end
	end

	assign rect.valid      = (cnt_q != '0);
	assign rect.width_px   = head.width_px;
	assign rect.height_px  = head.height_px;
	assign rect.landscape  = head.landscape;
	assign rect.degenerate = head.degenerate;

endmodule

[hw/rtl/quad_to_card_rect_size_unit.sv]
// ----------------------------------------------------------------------------
// quad_to_card_rect_size_unit: card rectangle size from a quadrilateral
// Side lengths, perspective-corrected orientation and card-aspect sizing.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                  | accepted when
//  --------+-----+------------------------------------------+-----------------
//  quad    | in  | four corners, x/y each                    | valid & ready
//  rect    | out | width_px, height_px, landscape, degenerate | valid & ready
//  cfg     | in  | long_edge_min                             | valid & ready
//
//  One item per cycle sustained while no stall holds the pipe. From input
//  acceptance to result acceptance an item passes three stages of
//  differences and squares, one square-root stage per side-length bit,
//  eight compare stages and four sizing stages, then the output queue.
//  Reset clears all valid bits, the queue and the register.
//  A stall holds every stage; the two-entry queue keeps taking items while a
//  result waits, and the whole pipe holds only once both entries are full.
//
module quad_to_card_rect_size_unit (
	input  logic     clk,
	input  logic     arst_n,
	qtc_quad_if.sink quad,
	qtc_rect_if.source rect,
	qtc_cfg_if.sink  cfg
);

	localparam int CB = qtc_pkg::COORD_BITS;
	localparam int NL = qtc_pkg::N_LANES;

	logic en;

	// register: long_edge_min, always writable
	logic [qtc_pkg::LEM_W-1:0] lem_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lem_q <= '0;
		end else if (cfg.valid) begin
			lem_q <= cfg.long_edge_min;
		end
	end

	// corners in order top-left, top-right, bottom-left, bottom-right
	logic [CB-1:0] px [NL];
	logic [CB-1:0] py [NL];

	always_comb begin
		px[0] = qtc_pkg::mask_coord(quad.top_left_x);
		py[0] = qtc_pkg::mask_coord(quad.top_left_y);
		px[1] = qtc_pkg::mask_coord(quad.top_right_x);
		py[1] = qtc_pkg::mask_coord(quad.top_right_y);
		px[2] = qtc_pkg::mask_coord(quad.bottom_left_x);
		py[2] = qtc_pkg::mask_coord(quad.bottom_left_y);
		px[3] = qtc_pkg::mask_coord(quad.bottom_right_x);
		py[3] = qtc_pkg::mask_coord(quad.bottom_right_y);
	end

	assign quad.ready = en;

	logic                            v_s1, v_s2, v_s3;
	logic [CB-1:0]                   dx_s1 [NL];
	logic [CB-1:0]                   dy_s1 [NL];
	logic [qtc_pkg::SQ_IN_W-1:0]     dx2_s2 [NL];
	logic [qtc_pkg::SQ_IN_W-1:0]     dy2_s2 [NL];
	logic [qtc_pkg::RAD_W-1:0]       rad_s3 [NL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= quad.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// top, bottom, left, right sides
			dx_s1[qtc_pkg::LN_TOP]   <= qtc_pkg::abs_diff(px[0], px[1]);
			dy_s1[qtc_pkg::LN_TOP]   <= qtc_pkg::abs_diff(py[0], py[1]);
			dx_s1[qtc_pkg::LN_BOT]   <= qtc_pkg::abs_diff(px[2], px[3]);
			dy_s1[qtc_pkg::LN_BOT]   <= qtc_pkg::abs_diff(py[2], py[3]);
			dx_s1[qtc_pkg::LN_LEFT]  <= qtc_pkg::abs_diff(px[0], px[2]);
			dy_s1[qtc_pkg::LN_LEFT]  <= qtc_pkg::abs_diff(py[0], py[2]);
			dx_s1[qtc_pkg::LN_RIGHT] <= qtc_pkg::abs_diff(px[1], px[3]);
			dy_s1[qtc_pkg::LN_RIGHT] <= qtc_pkg::abs_diff(py[1], py[3]);
			for (int l = 0; l < NL; l++) begin
				dx2_s2[l] <= dx_s1[l] * dx_s1[l];
				dy2_s2[l] <= dy_s1[l] * dy_s1[l];
				// scale by 2^16 so the root comes out in Q.8
				rad_s3[l] <= (qtc_pkg::RAD_W'(dx2_s2[l]) + qtc_pkg::RAD_W'(dy2_s2[l]))
					<< (2 * qtc_pkg::FRAC_BITS);
			end
		end
	end

	logic                       sq_valid;
	logic [qtc_pkg::SIDE_W-1:0] side [NL];

	qtc_isqrt4 u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.out_valid (sq_valid),
		.root      (side)
	);

	logic              cmp_valid;
	qtc_pkg::cmp_res_t cmp_res;

	qtc_ratio_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.side      (side),
		.out_valid (cmp_valid),
		.res       (cmp_res)
	);

	logic           size_valid;
	qtc_pkg::rect_t size_rect;

	qtc_sizer u_size (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cmp_valid),
		.res       (cmp_res),
		.lem       (lem_q),
		.out_valid (size_valid),
		.rect      (size_rect)
	);

	qtc_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (size_valid),
		.in_rect  (size_rect),
		.en       (en),
		.rect     (rect)
	);

endmodule

[tb/tb_channels.sv]
// ----------------------------------------------------------------------------
// tb_channels: testbench channel bundle
// Note that the RTL already provides the channel interfaces; this file only
// holds the shared item record used by the testbench.
// ----------------------------------------------------------------------------
package tb_quad_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [11:0] c [8];
	} quad_item_t;
endpackage

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: card rectangle sizing testbench
// Drives corner quads through the sizing unit with bursty input and a
// stalling output, predicts each rectangle with an exact integer model and
// compares every result field in order. The minimum long edge is swept
// across several values, extremes included, between idle phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = qtc_pkg::COORD_BITS + 25;
	localparam int CYCLE_CAP = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	qtc_quad_if quad ();
	qtc_rect_if rect ();
	qtc_cfg_if  cfg ();

	quad_to_card_rect_size_unit u_top (
		.clk(clk), .arst_n(arst_n), .quad(quad.sink), .rect(rect.source), .cfg(cfg.sink)
	);

	tb_quad_pkg::quad_item_t pending_quads[$];
	qtc_pkg::rect_t          expected_rects[$];
	logic [11:0] edge_min = '0;
	int  errors = 0;
	int  results_seen = 0;
	int  cycles = 0;
	bit  long_hold = 1'b0;
	bit  hold_input = 1'b0;

	// Side length in Q.8: integer square root of (dx^2 + dy^2) << 16.
	function automatic longint unsigned side_len(logic [11:0] ax, logic [11:0] ay,
		logic [11:0] bx, logic [11:0] by);
		longint unsigned dx, dy, n, res, b;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		n = (dx * dx + dy * dy) << 16;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic qtc_pkg::rect_t size_rect(tb_quad_pkg::quad_item_t q, logic [11:0] lem);
		longint unsigned t, bo, l, r, tbm, lrm, y, x, ysq_lr, den_lr, ysq_tb, den_tb;
		longint unsigned w, minw, h;
		logic [191:0] lhs, rhs;
		qtc_pkg::rect_t res;
		bit land, degen;
		t  = side_len(q.c[0], q.c[1], q.c[2], q.c[3]);
		bo = side_len(q.c[4], q.c[5], q.c[6], q.c[7]);
		l  = side_len(q.c[0], q.c[1], q.c[4], q.c[5]);
		r  = side_len(q.c[2], q.c[3], q.c[6], q.c[7]);
		tbm = (t < bo) ? t : bo;
		lrm = (l < r) ? l : r;
		degen = (tbm == 0) || (lrm == 0);
		land = 1'b0;
		if (!degen) begin
			y = (l > r) ? l : r;
			x = (l > r) ? l - r : r - l;
			ysq_lr = y * y;
			den_lr = y * y - x * x;
			y = (t > bo) ? t : bo;
			x = (t > bo) ? t - bo : bo - t;
			ysq_tb = y * y;
			den_tb = y * y - x * x;
			lhs = 192'(t + bo) * 192'(ysq_lr) * 192'(den_tb);
			rhs = 192'(l + r) * 192'(ysq_tb) * 192'(den_lr);
			land = lhs[127:0] > rhs[127:0];
		end
		w = tbm >> 8;
		minw = land ? lem : (longint'(lem) * qtc_pkg::CARD_SHORT) / qtc_pkg::CARD_LONG;
		if (w < minw)
			w = minw;
		if (w > qtc_pkg::W_MAX)
			w = qtc_pkg::W_MAX;
		h = land ? (w * qtc_pkg::CARD_SHORT) / qtc_pkg::CARD_LONG :
			(w * qtc_pkg::CARD_LONG) / qtc_pkg::CARD_SHORT;
		if (h > qtc_pkg::H_MAX)
			h = qtc_pkg::H_MAX;
		res.width_px   = w[qtc_pkg::W_W-1:0];
		res.height_px  = h[qtc_pkg::H_W-1:0];
		res.landscape  = land;
		res.degenerate = degen;
		return res;
	endfunction

	// Driver: bursts of random length with random gaps; predict on acceptance.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad.valid <= 1'b0;
		end else begin
			if (quad.valid && quad.ready) begin
				expected_rects = {expected_rects,
					size_rect(pending_quads.pop_front(), edge_min)};
			end
			if (quad.valid && !quad.ready) begin
				// hold the offered item
			end else if (hold_input || pending_quads.size() == 0 ||
				(quad.valid && quad.ready && pending_quads.size() == 0)) begin
				quad.valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				quad.valid <= 1'b0;
			end else begin
				// advance to the next pending item
				quad.valid <= 1'b1;
				quad.top_left_x     <= pending_quads[0].c[0];
				quad.top_left_y     <= pending_quads[0].c[1];
				quad.top_right_x    <= pending_quads[0].c[2];
				quad.top_right_y    <= pending_quads[0].c[3];
				quad.bottom_left_x  <= pending_quads[0].c[4];
				quad.bottom_left_y  <= pending_quads[0].c[5];
				quad.bottom_right_x <= pending_quads[0].c[6];
				quad.bottom_right_y <= pending_quads[0].c[7];
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// The head of the queue is popped only at the edge that accepts it, so the
	// item on the wires is always pending_quads[0] at its acceptance edge.

	// Monitor: the receiver stalls on its own pattern; compare in order.
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		qtc_pkg::rect_t want;
		if (!arst_n) begin
			rect.ready <= 1'b0;
		end else begin
			if (rect.valid && rect.ready) begin
				results_seen++;
				if (expected_rects.size() == 0) begin
					$error("result with nothing expected: w=%0d h=%0d",
						rect.width_px, rect.height_px);
					errors++;
				end else begin
					want = expected_rects.pop_front();
					if (rect.width_px !== want.width_px) begin
						$error("width_px expected %0d got %0d", want.width_px, rect.width_px);
						errors++;
					end
					if (rect.height_px !== want.height_px) begin
						$error("height_px expected %0d got %0d", want.height_px,
							rect.height_px);
						errors++;
					end
					if (rect.landscape !== want.landscape) begin
						$error("landscape expected %0b got %0b", want.landscape, rect.landscape);
						errors++;
					end
					if (rect.degenerate !== want.degenerate) begin
						$error("degenerate expected %0b got %0b", want.degenerate,
							rect.degenerate);
						errors++;
					end
				end
			end
			stall_phase <= (stall_phase + 1) % 97;
			if (long_hold)
				rect.ready <= 1'b0;
			else if (stall_phase < 30)
				rect.ready <= 1'b1;
			else
				rect.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Cycle cap: end the run with a failure once the cycle count passes CYCLE_CAP.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Quad builders.
	function automatic tb_quad_pkg::quad_item_t make_quad(int a, int b, int c, int d,
		int e, int f, int g, int h);
		tb_quad_pkg::quad_item_t q;
		q.c[0] = 12'(a); q.c[1] = 12'(b); q.c[2] = 12'(c); q.c[3] = 12'(d);
		q.c[4] = 12'(e); q.c[5] = 12'(f); q.c[6] = 12'(g); q.c[7] = 12'(h);
		return q;
	endfunction

	// A card-like quad: an axis rectangle with jittered corners.
	function automatic tb_quad_pkg::quad_item_t card_quad();
		int x0, y0, wd, ht, j;
		tb_quad_pkg::quad_item_t q;
		wd = $urandom_range(1, 2000);
		ht = $urandom_range(1, 2000);
		x0 = $urandom_range(0, 4095 - wd);
		y0 = $urandom_range(0, 4095 - ht);
		j = $urandom_range(0, 40);
		q = make_quad(x0, y0, x0 + wd, y0, x0, y0 + ht, x0 + wd, y0 + ht);
		for (int i = 0; i < 8; i++) begin
			q.c[i] = 12'(int'(q.c[i]) + $urandom_range(0, j) - j / 2);
		end
		return q;
	endfunction

	task automatic write_edge_min(logic [11:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.long_edge_min <= v;
		do @(posedge clk); while (!cfg.ready);
		edge_min = v;
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_quads.size() != 0 || quad.valid || expected_rects.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1: pending_quads = {pending_quads, make_quad($urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom)};
				2: begin
					// collapse a side to a point
					tb_quad_pkg::quad_item_t q;
					q = card_quad();
					if ($urandom_range(0, 1)) begin
						q.c[2] = q.c[0]; q.c[3] = q.c[1];
					end else begin
						q.c[4] = q.c[0]; q.c[5] = q.c[1];
					end
					pending_quads = {pending_quads, q};
				end
				default: pending_quads = {pending_quads, card_quad()};
			endcase
		end
	endtask

	logic [11:0] edge_values[6] = '{12'd0, 12'd4095, 12'd856, 12'd300, 12'd1500, 12'd1};

	initial begin
		quad.valid = 1'b0;
		quad.top_left_x = '0; quad.top_left_y = '0;
		quad.top_right_x = '0; quad.top_right_y = '0;
		quad.bottom_left_x = '0; quad.bottom_left_y = '0;
		quad.bottom_right_x = '0; quad.bottom_right_y = '0;
		rect.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.long_edge_min = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: all-zero, all-max, landscape, portrait, point sides, extremes.
		pending_quads = {pending_quads, make_quad(0, 0, 0, 0, 0, 0, 0, 0)};
		pending_quads = {pending_quads,
			make_quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095)};
		pending_quads = {pending_quads, make_quad(0, 0, 4095, 0, 0, 4095, 4095, 4095)};
		pending_quads = {pending_quads, make_quad(0, 0, 4095, 0, 0, 2580, 4095, 2580)};
		pending_quads = {pending_quads, make_quad(0, 0, 2580, 0, 0, 4095, 2580, 4095)};
		pending_quads = {pending_quads, make_quad(0, 0, 0, 0, 0, 100, 50, 100)};
		pending_quads = {pending_quads, make_quad(0, 0, 100, 0, 0, 0, 100, 60)};
		pending_quads = {pending_quads, make_quad(4095, 0, 0, 4095, 0, 4095, 4095, 0)};
		pending_quads = {pending_quads, make_quad(10, 10, 11, 10, 10, 11, 11, 11)};
		pending_quads = {pending_quads, make_quad(100, 100, 957, 120, 90, 640, 940, 660)};
		pending_quads = {pending_quads,
			make_quad(2730, 1365, 1365, 2730, 2730, 2730, 1365, 1365)};
		pending_quads = {pending_quads, make_quad(0, 0, 3, 0, 0, 2, 3, 2)};
		drain();

		for (int p = 0; p < 6; p++) begin
			write_edge_min(edge_values[p]);
			random_phase(200);
			if (p == 2) begin
				// hold off the receiver so the pipe fills and stalls its input
				long_hold = 1'b1;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			if (p == 4) begin
				// pause the sender until every expected result has come
				while (pending_quads.size() != 0)
					@(posedge clk);
				hold_input = 1'b1;
				while (expected_rects.size() != 0)
					@(posedge clk);
				hold_input = 1'b0;
				random_phase(50);
			end
			drain();
		end

		$display("Covered %0d rectangles over 6 minimum-edge settings, including", results_seen);
		$display("point sides, extreme corners, and full-pipe stalls.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
